>>> rtl/core/fmsd_pkg.sv
// ----------------------------------------------------------------------------
// fmsd_pkg
// Shared field widths and item codes for the multi-server dispatcher.
// ----------------------------------------------------------------------------
package fmsd_pkg;

  localparam int DUR_W   = 16;  // service duration
  localparam int ACT_W   = 5;   // active server register
  localparam int START_W = 5;   // jobs started in one tick
  localparam int QLEN_W  = 13;  // reported queue length
  localparam int TOT_W   = 32;  // saturating totals

  // item kinds carried on the mode field
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

endpackage

>>> rtl/core/fifo_multi_server_dispatcher.sv
// ----------------------------------------------------------------------------
// fifo_multi_server_dispatcher
// Multi-server job dispatcher fed by a circular job FIFO.
// ----------------------------------------------------------------------------
// Arrival item: result registered in the cycle after acceptance; one item per
//   cycle while out_ready takes each result. Tick item over n = min(active_servers,
//   MAX_SERVERS) servers: next item taken once the scan ends and its result is
//   taken (a tick with n = 0 only reports state). The scan reads one server entry
//   per cycle from the server memory and evaluates each entry after its read.
// Reset: pointers, queue count, totals and server times clear, active_servers
//   returns to 1; the job memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module fifo_multi_server_dispatcher import fmsd_pkg::*; #(
  parameter int FIFO_DEPTH  = 4096,
  parameter int MAX_SERVERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [ACT_W-1:0]   cfg_wdata,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [DUR_W-1:0]   service_time,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic               accepted,
  output logic [START_W-1:0] started_now,
  output logic [QLEN_W-1:0]  queue_length,
  output logic [TOT_W-1:0]   total_served,
  output logic [TOT_W-1:0]   duration_sum
);

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int WCNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int SIDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W  = $clog2(MAX_SERVERS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic               state, state_next;
  logic [ACT_W-1:0]   active_servers;
  logic [PTR_W-1:0]   head, head_next;
  logic [PTR_W-1:0]   tail, tail_next;
  logic [WCNT_W-1:0]  waiting, waiting_next;
  logic [TOT_W-1:0]   served_total, served_total_next;
  logic [TOT_W-1:0]   duration_total, duration_total_next;
  logic [CNT_W-1:0]   n_lat, n_lat_next;
  logic [CNT_W-1:0]   iss_cnt, iss_cnt_next;
  logic               ev_act;      // a server is evaluated this cycle
  logic [SIDX_W-1:0]  ev_idx;
  logic               ev_last;
  logic               deq_prev;    // previous evaluated server took the head
  logic [START_W-1:0] started, started_next;

  // ---------------------------------------------------------------------------
  // Combinational control
  // ---------------------------------------------------------------------------
  logic               in_fire;
  logic               out_fire;
  logic [CNT_W-1:0]   n_clamped;
  logic               iss_act;
  logic               iss_last;
  logic [SIDX_W-1:0]  iss_idx;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   tail_inc;
  logic               queue_full;
  logic               deq;
  logic               produce;
  logic               res_accepted;

  // memory ports
  logic               js_wr_en;
  logic [DUR_W-1:0]   js_rd_a, js_rd_b;
  logic [DUR_W-1:0]   head_job;
  logic               sb_wr_en;
  logic [DUR_W-1:0]   sb_wr_data;
  logic [DUR_W-1:0]   srv_rem;
  logic [TOT_W:0]     dur_sum_wide;
  logic [31:0]        waiting_ext;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // clamp the visited server count to the servers that exist
  always_comb begin
    if (32'(active_servers) > 32'(MAX_SERVERS)) begin
      n_clamped = CNT_W'(MAX_SERVERS);
    end else begin
      n_clamped = CNT_W'(active_servers);
    end
  end

  assign head_inc   = (head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign tail_inc   = (tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
  assign queue_full = (waiting == WCNT_W'(FIFO_DEPTH));

  // issue side: one server read per cycle while the scan runs
  assign iss_act  = (state == S_RUN) && (iss_cnt != n_lat);
  assign iss_last = (iss_cnt == n_lat - CNT_W'(1));
  assign iss_idx  = SIDX_W'(iss_cnt);

  // both head and head+1 were read last cycle; pick by last cycle's dequeue
  assign head_job = deq_prev ? js_rd_b : js_rd_a;

  assign js_wr_en = in_fire && (mode == MODE_ARRIVAL) && !queue_full;

  always_comb begin
    state_next          = state;
    head_next           = head;
    tail_next           = tail;
    waiting_next        = waiting;
    served_total_next   = served_total;
    duration_total_next = duration_total;
    n_lat_next          = n_lat;
    iss_cnt_next        = iss_cnt;
    started_next        = started;
    deq                 = 1'b0;
    sb_wr_en            = 1'b0;
    sb_wr_data          = srv_rem - DUR_W'(1);
    produce             = 1'b0;
    res_accepted        = 1'b1;
    dur_sum_wide        = {1'b0, duration_total} + (TOT_W + 1)'(head_job);

    if (in_fire) begin
      if (mode == MODE_ARRIVAL) begin
        produce = 1'b1;
        if (queue_full) begin
          res_accepted = 1'b0;
        end else begin
          tail_next    = tail_inc;
          waiting_next = waiting + WCNT_W'(1);
        end
      end else if (n_clamped == '0) begin
        // no server to visit: report state only
        produce = 1'b1;
      end else begin
        state_next   = S_RUN;
        n_lat_next   = n_clamped;
        iss_cnt_next = '0;
        started_next = '0;
      end
    end

    if (iss_act) begin
      iss_cnt_next = iss_cnt + CNT_W'(1);
    end

    if (ev_act) begin
      if (srv_rem != '0) begin
        // busy: count down
        sb_wr_en = 1'b1;
      end else if (waiting != '0) begin
        // idle: take the head job
        deq                 = 1'b1;
        sb_wr_en            = 1'b1;
        sb_wr_data          = head_job;
        head_next           = head_inc;
        waiting_next        = waiting - WCNT_W'(1);
        started_next        = started + START_W'(1);
        served_total_next   = (&served_total) ? served_total
                                              : served_total + TOT_W'(1);
        duration_total_next = dur_sum_wide[TOT_W] ? '1 : dur_sum_wide[TOT_W-1:0];
      end
      if (ev_last) begin
        produce    = 1'b1;
        state_next = S_IDLE;
      end
    end
  end

  assign waiting_ext = 32'(waiting_next);

  // ---------------------------------------------------------------------------
  // Sequential state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      active_servers <= ACT_W'(1);
      head           <= '0;
      tail           <= '0;
      waiting        <= '0;
      served_total   <= '0;
      duration_total <= '0;
      n_lat          <= '0;
      iss_cnt        <= '0;
      ev_act         <= 1'b0;
      ev_last        <= 1'b0;
      deq_prev       <= 1'b0;
      started        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_servers <= cfg_wdata;
      end
      state          <= state_next;
      head           <= head_next;
      tail           <= tail_next;
      waiting        <= waiting_next;
      served_total   <= served_total_next;
      duration_total <= duration_total_next;
      n_lat          <= n_lat_next;
      iss_cnt        <= iss_cnt_next;
      ev_act         <= iss_act;
      ev_last        <= iss_last;
      deq_prev       <= deq;
      started        <= started_next;
      if (produce) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // evaluate index and result payload: no reset needed
  always_ff @(posedge clk) begin
    ev_idx <= iss_idx;
    if (produce) begin
      accepted     <= res_accepted;
      started_now  <= (state == S_RUN) ? started_next : '0;
      queue_length <= waiting_ext[QLEN_W-1:0];
      total_served <= served_total_next;
      duration_sum <= duration_total_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  fmsd_job_store #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_job_store (
    .clk       (clk),
    .wr_en     (js_wr_en),
    .wr_addr   (tail),
    .wr_data   (service_time),
    .rd_addr_a (head),
    .rd_addr_b (head_inc),
    .rd_data_a (js_rd_a),
    .rd_data_b (js_rd_b)
  );

  fmsd_server_bank #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_server_bank (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (iss_idx),
    .wr_en   (sb_wr_en),
    .wr_idx  (ev_idx),
    .wr_data (sb_wr_data),
    .rd_data (srv_rem)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    waiting <= WCNT_W'(FIFO_DEPTH))
    else $error("queue count beyond FIFO depth");

  a_no_result_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> !out_valid)
    else $error("result pending while a tick scan runs");

  a_started_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (32'(started) <= 32'(n_lat)))
    else $error("more jobs started than servers visited");

  a_arrival_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (mode == MODE_ARRIVAL) && !queue_full)
      |=> (waiting == $past(waiting) + WCNT_W'(1)))
    else $error("stored arrival did not advance the queue count");

  a_eval_follows_issue: assert property (@(posedge clk) disable iff (rst)
    ev_act |-> (state == S_RUN))
    else $error("server evaluated outside a tick scan");

endmodule

>>> rtl/core/fmsd_job_store.sv
// ----------------------------------------------------------------------------
// fmsd_job_store
// Circular job memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fmsd_job_store import fmsd_pkg::*; #(
  parameter int FIFO_DEPTH = 4096,
  localparam int PTR_W = $clog2(FIFO_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [PTR_W-1:0] wr_addr,
  input  logic [DUR_W-1:0] wr_data,
  input  logic [PTR_W-1:0] rd_addr_a,
  input  logic [PTR_W-1:0] rd_addr_b,
  output logic [DUR_W-1:0] rd_data_a,
  output logic [DUR_W-1:0] rd_data_b
);

  logic [DUR_W-1:0] mem [FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> rtl/core/fmsd_server_bank.sv
// ----------------------------------------------------------------------------
// fmsd_server_bank
// Remaining-time memory for the servers; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module fmsd_server_bank import fmsd_pkg::*; #(
  parameter int MAX_SERVERS = 16,
  localparam int SIDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIDX_W-1:0] rd_idx,
  input  logic              wr_en,
  input  logic [SIDX_W-1:0] wr_idx,
  input  logic [DUR_W-1:0]  wr_data,
  output logic [DUR_W-1:0]  rd_data
);

  logic [DUR_W-1:0] mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld;
  logic [DUR_W-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_q <= mem[rd_idx];
  end

  // valid bits stand in for a reset sweep of the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
      rd_vld_q <= vld[rd_idx];
    end
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
